// ===== sv/igp_pkg.sv =====
// Shared constants and types for the im2col patch gather block.
// No dependencies; every file but igp_checker imports this package.
package igp_pkg;

    localparam int PLANE_WORDS   = 4096;
    localparam int MAX_KERNEL    = 8;
    localparam int DILATION_ROWS = 1;
    localparam int DILATION_COLS = 1;

    localparam int AW          = $clog2(PLANE_WORDS);
    localparam int ADDR_W      = 27;   // 13b col * 13b height + 13b row
    localparam int BASE_W      = 18;   // signed source row/col offsets
    localparam int KN_W        = 4;    // kernel sizes and tap counters
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EMIT  = 1'b1;

    localparam logic [2:0] REG_INPUT_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH   = 3'd1;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_STRIDE_ROWS   = 3'd4;
    localparam logic [2:0] REG_STRIDE_COLS   = 3'd5;
    localparam logic [2:0] REG_PAD_ROWS      = 3'd6;
    localparam logic [2:0] REG_PAD_COLS      = 3'd7;

    typedef struct packed {
        logic [12:0] input_height;
        logic [12:0] input_width;
        logic [3:0]  kernel_height;
        logic [3:0]  kernel_width;
        logic [3:0]  stride_rows;
        logic [3:0]  stride_cols;
        logic [2:0]  pad_rows;
        logic [2:0]  pad_cols;
    } cfg_t;

    // One classified command between front and back.
    typedef struct packed {
        logic                     command;
        logic [11:0]              pixel_index;
        logic [31:0]              pixel_word;
        logic signed [BASE_W-1:0] base_row;
        logic signed [BASE_W-1:0] base_col;
    } q_entry_t;

    function automatic logic [KN_W-1:0] clamp_kernel(input logic [3:0] k);
        logic [KN_W-1:0] r;
        if (k > KN_W'(MAX_KERNEL))
            r = KN_W'(MAX_KERNEL);
        else
            r = KN_W'(k);
        return r;
    endfunction

endpackage

// ===== sv/im2col_patch_gather.sv =====
// Top level of the im2col patch gather: configuration registers, front end,
// command queue and back end. Depends on igp_pkg, igp_front, igp_queue, igp_back.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: index, word, out_row, out_col; s_tuser: command
//  m_*       out  m_tvalid/m_tready  m_tdata: tap_word; m_tuser: is_padding; m_tlast: last
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// An emit first loads the window origin into the sequencer, then gives
// kernel_height*kernel_width taps, each size clamped to MAX_KERNEL, at one tap
// per cycle while the output is not stalled, set by the single read port of the
// plane store. The queue holds four commands, so the input side keeps
// accepting while taps drain. A stall on m_tready freezes the whole back end
// pipeline. Reset clears control state and config registers; the plane store
// is not cleared.
module im2col_patch_gather
    import igp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // pixel_index[11:0], pixel_word[43:12], out_row[55:44],
                                   // out_col[67:56], zero[71:68]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tap_word[31:0]
    output logic        m_tuser,   // is_padding
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    q_entry_t q_in;
    q_entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_height  <= 13'd1;
            cfg_reg.input_width   <= 13'd1;
            cfg_reg.kernel_height <= 4'd1;
            cfg_reg.kernel_width  <= 4'd1;
            cfg_reg.stride_rows   <= 4'd1;
            cfg_reg.stride_cols   <= 4'd1;
            cfg_reg.pad_rows      <= 3'd0;
            cfg_reg.pad_cols      <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_HEIGHT:  cfg_reg.input_height  <= cfg_data;
                REG_INPUT_WIDTH:   cfg_reg.input_width   <= cfg_data;
                REG_KERNEL_HEIGHT: cfg_reg.kernel_height <= cfg_data[3:0];
                REG_KERNEL_WIDTH:  cfg_reg.kernel_width  <= cfg_data[3:0];
                REG_STRIDE_ROWS:   cfg_reg.stride_rows   <= cfg_data[3:0];
                REG_STRIDE_COLS:   cfg_reg.stride_cols   <= cfg_data[3:0];
                REG_PAD_ROWS:      cfg_reg.pad_rows      <= cfg_data[2:0];
                REG_PAD_COLS:      cfg_reg.pad_cols      <= cfg_data[2:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    igp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    igp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    igp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== sv/igp_front.sv =====
// Front end: accepts stream transactions, unpacks them and works out the
// window origin of an emit. Depends on igp_pkg.
module igp_front
    import igp_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // pixel_index[11:0], pixel_word[43:12], out_row[55:44],
                                   // out_col[67:56], zero[71:68]
    input  logic        s_tuser,   // command
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output q_entry_t    q_entry
);

    logic [11:0] out_row;
    logic [11:0] out_col;
    logic [15:0] prod_row;
    logic [15:0] prod_col;

    assign out_row  = s_tdata[55:44];
    assign out_col  = s_tdata[67:56];
    assign prod_row = 16'(out_row) * 16'(cfg.stride_rows);
    assign prod_col = 16'(out_col) * 16'(cfg.stride_cols);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_entry.command     = s_tuser;
        q_entry.pixel_index = s_tdata[11:0];
        q_entry.pixel_word  = s_tdata[43:12];
        // origin = position * stride - pad, may go negative
        q_entry.base_row    = $signed(BASE_W'(prod_row)) - $signed(BASE_W'(cfg.pad_rows));
        q_entry.base_col    = $signed(BASE_W'(prod_col)) - $signed(BASE_W'(cfg.pad_cols));
    end

endmodule

// ===== sv/igp_queue.sv =====
// Short command queue between front and back end.
// Depends on igp_pkg.
module igp_queue
    import igp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t head
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/igp_back.sv =====
// Back end: tap sequencer, address pipeline, plane store and output register.
// Depends on igp_pkg.
module igp_back
    import igp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_not_empty,
    input  q_entry_t    q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tap_word
    output logic        m_tuser,   // is_padding
    output logic        m_tlast
);

    logic [31:0] store_mem [PLANE_WORDS];

    logic [KN_W-1:0] kh_n;
    logic [KN_W-1:0] kw_n;
    logic            adv;

    // sequencer
    logic                     busy_reg, busy_next;
    logic [KN_W-1:0]          kr_reg, kr_next;
    logic [KN_W-1:0]          kc_reg, kc_next;
    logic signed [BASE_W-1:0] base_row_reg;
    logic signed [BASE_W-1:0] base_col_reg;
    logic signed [BASE_W-1:0] src_row;
    logic signed [BASE_W-1:0] src_col;
    logic                     row_in;
    logic                     col_in;
    logic                     tap_last;
    logic                     load_emit;

    // stage 1: source coordinates or write command
    logic        v1_reg, v1_next;
    logic        wr1_reg;
    logic        last1_reg;
    logic        pad1_reg;
    logic [12:0] row1_reg;
    logic [12:0] col1_reg;
    logic [11:0] idx1_reg;
    logic [31:0] word1_reg;

    // stage 2: store address
    logic              v2_reg;
    logic              wr2_reg;
    logic              last2_reg;
    logic              pad2_reg;
    logic [ADDR_W-1:0] addr2_reg;
    logic [31:0]       word2_reg;
    logic              in_store2;

    // stage 3: store read data
    logic        v3_reg;
    logic        last3_reg;
    logic        pad3_reg;
    logic        zero3_reg;
    logic [31:0] rd3_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic        out_pad_reg;
    logic        out_last_reg;

    assign kh_n = clamp_kernel(cfg.kernel_height);
    assign kw_n = clamp_kernel(cfg.kernel_width);

    // whole pipeline moves together whenever the output register can take a tap
    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && !busy_reg && q_not_empty;

    assign src_row = base_row_reg + $signed(BASE_W'(kr_reg) * BASE_W'(DILATION_ROWS));
    assign src_col = base_col_reg + $signed(BASE_W'(kc_reg) * BASE_W'(DILATION_COLS));
    assign row_in  = !src_row[BASE_W-1] &&
                     (src_row[BASE_W-2:0] < (BASE_W-1)'(cfg.input_height));
    assign col_in  = !src_col[BASE_W-1] &&
                     (src_col[BASE_W-2:0] < (BASE_W-1)'(cfg.input_width));
    assign tap_last = (kr_reg == kh_n - 1'b1) && (kc_reg == kw_n - 1'b1);

    // empty kernel: emit is dropped with no taps
    assign load_emit = q_pop && (q_head.command == CMD_EMIT) &&
                       (kh_n != '0) && (kw_n != '0);

    always_comb
    begin
        busy_next = busy_reg;
        kr_next   = kr_reg;
        kc_next   = kc_reg;
        v1_next   = v1_reg;
        if (adv)
        begin
            v1_next = busy_reg || (q_pop && q_head.command == CMD_WRITE);
            if (busy_reg)
            begin
                if (tap_last)
                    busy_next = 1'b0;
                if (kr_reg == kh_n - 1'b1)
                begin
                    kr_next = '0;
                    kc_next = kc_reg + 1'b1;
                end
                else
                begin
                    kr_next = kr_reg + 1'b1;
                end
            end
            else if (load_emit)
            begin
                busy_next = 1'b1;
                kr_next   = '0;
                kc_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kr_reg        <= '0;
            kc_reg        <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            kr_reg   <= kr_next;
            kc_reg   <= kc_next;
            v1_reg   <= v1_next;
            if (adv)
            begin
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg && !wr2_reg;
                out_valid_reg <= v3_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_emit)
        begin
            base_row_reg <= q_head.base_row;
            base_col_reg <= q_head.base_col;
        end
        if (adv)
        begin
            wr1_reg   <= !busy_reg;
            last1_reg <= tap_last;
            pad1_reg  <= !(row_in && col_in);
            row1_reg  <= src_row[12:0];
            col1_reg  <= src_col[12:0];
            idx1_reg  <= q_head.pixel_index;
            word1_reg <= q_head.pixel_word;

            wr2_reg   <= wr1_reg;
            last2_reg <= last1_reg;
            pad2_reg  <= pad1_reg;
            word2_reg <= word1_reg;
            if (wr1_reg)
                addr2_reg <= ADDR_W'(idx1_reg);
            else
                addr2_reg <= ADDR_W'(col1_reg) * ADDR_W'(cfg.input_height) +
                             ADDR_W'(row1_reg);

            last3_reg <= last2_reg;
            pad3_reg  <= pad2_reg;
            zero3_reg <= pad2_reg || !in_store2;

            out_word_reg <= zero3_reg ? 32'd0 : rd3_reg;
            out_pad_reg  <= pad3_reg;
            out_last_reg <= last3_reg;
        end
    end

    assign in_store2 = (addr2_reg < ADDR_W'(PLANE_WORDS));

    // plane store: writes and reads share stage 2, so command order is kept
    always_ff @(posedge clk)
    begin
        if (adv && v2_reg && wr2_reg && in_store2)
            store_mem[addr2_reg[AW-1:0]] <= word2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v2_reg && !wr2_reg && in_store2)
            rd3_reg <= store_mem[addr2_reg[AW-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_pad_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/igp_checker.sv =====
// Port-level checks for im2col_patch_gather, attached by bind.
// Depends only on the top level's ports.
module igp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // padded taps always carry a zero word
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("padded tap with nonzero word");

    // output register is cleared by reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // input side always answers a pending transaction with a known ready
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tready))
        else $error("s_tready unknown while s_tvalid high");

    // a pending transaction is not withdrawn
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled transaction keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
        ($stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("m_* payload changed while stalled");

endmodule

bind im2col_patch_gather igp_checker u_igp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
